// ===== src/lpcpns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpcpns_pkg;

  localparam int MAX_TAPS   = 32;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int ORDER_W    = 6;
  localparam int DEF_PITCH  = 100;
  localparam int NOISE_MID  = 16384;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes carried in the input item.
  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PFACT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USEEXT = 2'd2;

  // What a product of the shared multiplier stands for.
  typedef enum logic [1:0] {
    TAG_TAP,
    TAG_PULSE,
    TAG_NOISE
  } mul_tag_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         coef_index;
    logic signed [23:0] coef_value;
    logic [11:0]        pitch_period;
    logic [23:0]        frame_gain;
    logic signed [23:0] ext_sample;
    logic               ext_valid;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               clipped;
  } out_t;

  // Request to and status from the reload divider.
  typedef struct packed {
    logic        start;
    logic [19:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/lpcpns_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpcpns_mul
  import lpcpns_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               vld_in,
  input  wire mul_tag_t           tag_in,
  input  wire logic signed [32:0] a_in,
  input  wire logic signed [24:0] b_in,
  output logic                    vld_out,
  output mul_tag_t                tag_out,
  output logic signed [57:0]      prod_out
);

  logic                vld_r;
  mul_tag_t            tag_r;
  logic signed [57:0]  prod_r;

  // One registered signed multiply per cycle, shared by all product kinds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    tag_r  <= tag_in;
    prod_r <= a_in * b_in;
  end

  assign vld_out  = vld_r;
  assign tag_out  = tag_r;
  assign prod_out = prod_r;

endmodule
`default_nettype wire

// ===== src/lpcpns_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpcpns_div
  import lpcpns_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [16:0] rem_r;
  logic [19:0] dvd_r;
  logic [15:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [17:0] diff;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r[15:0], dvd_r[19]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd19) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (!busy_r && req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= diff[17] ? trial : diff[16:0];
      dvd_r <= {dvd_r[18:0], ~diff[17]};
    end
  end

  // The quotient saturates to the counter range.
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = (|dvd_r[19:16]) ? 16'hFFFF : dvd_r[15:0];

endmodule
`default_nettype wire

// ===== src/lpc_pulse_noise_resynthesizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Coefficient write and frame start: taken without leaving the idle state, except on the first frame,
// which waits while the 20-step reload divider runs (no division when the pitch factor is zero).
// Sample tick: any excitation product, then one tap per cycle through the one shared multiplier,
// then rounding; when a pulse fires and the divider runs, the rounding waits until it has finished.
// One item at a time; the result waits in an output register.
// Reset (synchronous, rst_n low) clears history valid bits and all control state.
module lpc_pulse_noise_resynthesizer
  import lpcpns_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EXC,
    S_TAP,
    S_ROUND
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [ORDER_W-1:0] order_r;
  logic signed [15:0] pf_r;
  logic               use_ext_r;

  // Frame and excitation state.
  logic [15:0]        cnt_r;
  logic [11:0]        cur_pitch_r;
  logic [11:0]        prev_pitch_r;
  logic [23:0]        gain_r;
  logic [14:0]        lfsr_r;
  logic               first_r;
  logic               exhausted_r;

  // Tick work registers.
  logic signed [63:0] acc_r;
  mul_tag_t           exc_tag_r;
  logic               exc_mul_r;
  logic [11:0]        exc_p_r;
  logic [ORDER_W-1:0] k_r;
  logic               rd_v_r;
  logic [TAP_AW-1:0]  rd_idx_r;
  logic signed [31:0] hist_q_r;
  logic               hv_q_r;
  logic signed [23:0] coef_q_r;
  logic signed [31:0] prev_h_r;
  logic [MAX_TAPS-1:0] hv_r;
  logic               out_valid_r;
  out_t               out_r;

  // Memories.
  logic signed [31:0] hist_mem [MAX_TAPS];
  logic signed [23:0] coef_mem [MAX_TAPS];

  logic               in_xfer;
  logic               out_xfer;
  logic [ORDER_W-1:0] order_use;
  logic               ext_active;
  logic               pf_pos;
  logic               pf_zero;
  logic               tick_noise;
  logic               tick_pulse;
  logic [11:0]        pulse_p;
  logic [15:0]        pf_mag;
  logic [14:0]        lfsr_nxt;
  logic signed [31:0] hist_rd;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               mul_vi;
  mul_tag_t           mul_ti;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic               mul_vo;
  mul_tag_t           mul_to;
  logic signed [57:0] mul_p;
  logic signed [63:0] prod_ext;
  logic signed [63:0] prod_scaled;
  logic signed [63:0] rnd_sum;
  logic signed [43:0] rnd_val;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [31:0] val;
  logic               round_go;
  logic               taps_done;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Excitation selection from the present state.
  assign order_use  = (order_r > ORDER_W'(MAX_TAPS)) ? ORDER_W'(MAX_TAPS) : order_r;
  assign ext_active = use_ext_r && !exhausted_r;
  assign pf_pos     = !pf_r[15] && (pf_r != 16'sd0);
  assign pf_zero    = (pf_r == 16'sd0);
  assign tick_noise = !ext_active && ((pf_pos && cur_pitch_r == 12'd0) || pf_zero);
  assign tick_pulse = !ext_active && !tick_noise && (cnt_r <= 16'd1);
  assign pulse_p    = pf_pos ? cur_pitch_r : prev_pitch_r;
  assign pf_mag     = pf_r[15] ? 16'(-pf_r) : 16'(pf_r);
  assign lfsr_nxt   = {lfsr_r[13:0], lfsr_r[14] ^ lfsr_r[13]};

  // Reload divider requests, from a tick pulse or from the first frame.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {pulse_p, 8'd0};
    div_req.divisor  = pf_mag;
    if (in_xfer && in_data.cmd == CMD_TICK && tick_pulse) begin
      div_req.start = 1'b1;
    end else if (in_xfer && in_data.cmd == CMD_FRAME && first_r && !pf_zero) begin
      div_req.start    = 1'b1;
      div_req.dividend = pf_pos ? {in_data.pitch_period, 8'd0} : {12'(DEF_PITCH), 8'd0};
    end
  end

  lpcpns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Shared multiplier operands: excitation product first, then one tap per cycle.
  assign hist_rd = hv_q_r ? hist_q_r : 32'sd0;
  always_comb begin
    if (state_r == S_EXC) begin
      mul_vi = exc_mul_r;
      mul_ti = exc_tag_r;
      mul_a  = {9'd0, gain_r};
      if (exc_tag_r == TAG_NOISE) begin
        mul_b = 25'(signed'({1'b0, lfsr_r}) - 16'sd16384);
      end else begin
        mul_b = {13'd0, exc_p_r};
      end
    end else begin
      mul_vi = rd_v_r;
      mul_ti = TAG_TAP;
      mul_a  = 33'(hist_rd);
      mul_b  = 25'(coef_q_r);
    end
  end

  lpcpns_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (mul_vi),
    .tag_in   (mul_ti),
    .a_in     (mul_a),
    .b_in     (mul_b),
    .vld_out  (mul_vo),
    .tag_out  (mul_to),
    .prod_out (mul_p)
  );

  // Scale the product into the Q43 accumulator.
  assign prod_ext = 64'(mul_p);
  always_comb begin
    unique case (mul_to)
      TAG_PULSE: prod_scaled = (prod_ext <<< 24) + (prod_ext <<< 23);
      TAG_NOISE: prod_scaled = (prod_ext <<< 13) + (prod_ext <<< 11);
      default:   prod_scaled = prod_ext;
    endcase
  end

  // Round once to Q23 and saturate.
  assign rnd_sum = acc_r + 64'sd524288;
  assign rnd_val = 44'(rnd_sum >>> 20);
  assign sat_hi  = rnd_val > 44'sd2147483647;
  assign sat_lo  = rnd_val < -44'sd2147483648;
  assign val     = sat_hi ? 32'sh7FFFFFFF : (sat_lo ? 32'sh80000000 : 32'(rnd_val));

  assign taps_done = (k_r >= order_use) && !rd_v_r && !mul_vo;
  assign round_go  = (state_r == S_ROUND) && !div_rsp.busy && (!out_valid_r || out_ready);

  // Memory ports: coefficient writes, history shift and history head write.
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.cmd == CMD_COEF) begin
      coef_mem[in_data.coef_index] <= in_data.coef_value;
    end
    if (state_r == S_TAP && k_r < order_use) begin
      hist_q_r <= hist_mem[k_r[TAP_AW-1:0]];
      coef_q_r <= coef_mem[k_r[TAP_AW-1:0]];
    end
    if (rd_v_r && rd_idx_r != '0) begin
      hist_mem[rd_idx_r] <= prev_h_r;
    end else if (round_go) begin
      hist_mem[0] <= val;
    end
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      order_r      <= ORDER_W'(10);
      pf_r         <= 16'sd256;
      use_ext_r    <= 1'b0;
      cnt_r        <= '0;
      cur_pitch_r  <= 12'(DEF_PITCH);
      prev_pitch_r <= 12'(DEF_PITCH);
      gain_r       <= '0;
      lfsr_r       <= 15'd1;
      first_r      <= 1'b1;
      exhausted_r  <= 1'b0;
      hv_r         <= '0;
      rd_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      exc_mul_r    <= 1'b0;
      k_r          <= '0;
    end else begin
      // Configuration writes; an index beyond the list is ignored.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORDER:  order_r   <= cfg_wdata[ORDER_W-1:0];
          CFG_PFACT:  pf_r      <= signed'(cfg_wdata);
          CFG_USEEXT: use_ext_r <= cfg_wdata[0];
          default:    ;
        endcase
      end

      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      // A finished division reloads the period counter.
      if (div_rsp.done) begin
        cnt_r <= div_rsp.quot;
      end

      rd_v_r <= 1'b0;
      if (rd_v_r) begin
        prev_h_r <= hist_rd;
        if (rd_idx_r != '0) begin
          hv_r[rd_idx_r] <= 1'b1;
        end
      end
      if (mul_vo) begin
        acc_r <= acc_r + prod_scaled;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_data.cmd)
              CMD_FRAME: begin
                if (first_r) begin
                  prev_pitch_r <= cur_pitch_r;
                  first_r      <= 1'b0;
                  if (pf_zero) begin
                    cnt_r <= 16'hFFFF;
                  end else begin
                    state_r <= S_DIV;
                  end
                end else if (cur_pitch_r != 12'd0) begin
                  prev_pitch_r <= cur_pitch_r;
                end
                cur_pitch_r <= in_data.pitch_period;
                gain_r      <= in_data.frame_gain;
              end
              CMD_TICK: begin
                acc_r     <= '0;
                exc_mul_r <= 1'b0;
                exc_tag_r <= TAG_PULSE;
                exc_p_r   <= pulse_p;
                k_r       <= '0;
                state_r   <= S_EXC;
                if (ext_active) begin
                  if (in_data.ext_valid) begin
                    acc_r <= 64'(in_data.ext_sample) <<< 21;
                  end else begin
                    exhausted_r <= 1'b1;
                  end
                end else if (tick_noise) begin
                  lfsr_r    <= lfsr_nxt;
                  exc_mul_r <= 1'b1;
                  exc_tag_r <= TAG_NOISE;
                end else if (tick_pulse) begin
                  exc_mul_r <= 1'b1;
                end else begin
                  cnt_r <= cnt_r - 16'd1;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_IDLE;
          end
        end
        S_EXC: begin
          state_r <= S_TAP;
        end
        S_TAP: begin
          if (k_r < order_use) begin
            rd_v_r   <= 1'b1;
            rd_idx_r <= k_r[TAP_AW-1:0];
            hv_q_r   <= hv_r[k_r[TAP_AW-1:0]];
            k_r      <= k_r + ORDER_W'(1);
          end else if (taps_done) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (round_go) begin
            hv_r[0]           <= 1'b1;
            out_r.sample_out  <= val;
            out_r.clipped     <= sat_hi || sat_lo;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/lpcpns_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpcpns_chk
  import lpcpns_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire in_t                   in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_t                  out_data,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A stalled result transfer keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result transfer keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // A clipped sample sits at one of the two rails.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      (out_data.sample_out == 32'sh7FFFFFFF) || (out_data.sample_out == 32'sh80000000))
    else $error("clipped flag without a saturated sample");

  // A new result comes only from a tick that was still being worked on.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind lpc_pulse_noise_resynthesizer lpcpns_chk u_lpcpns_chk (.*);
`default_nettype wire
